FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Include with the bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check with no reset qualification.
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked check that is ignored while reset is held.
`define CHK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: design/fkaes_pkg.sv
`timescale 1ns / 1ps
// Types, constants and round functions for the fixed-key AES tweak hash.
// No dependencies; used by the top level and its checker.
package fkaes_pkg;

  localparam int HALF_W   = 64;
  localparam int BLOCK_W  = 128;
  localparam int CFG_IDX_W = 8;
  localparam int ROUNDS   = 10;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [3:0]         round_idx_t;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_HIGH = 8'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round on a little-endian byte state; the last round skips MixColumns.
  function automatic block_t aes_round(input block_t s, input block_t rk, input logic last);
    logic [7:0] o [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    block_t     r;
    for (int i = 0; i < 16; i++) begin
      o[i] = SBOX[s[8*i +: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = o[i + 4*((c + i) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = (last ? t[i] : m[i]) ^ rk[8*i +: 8];
    end
    return r;
  endfunction

  // Next AES-128 round key from the previous one.
  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    w0 = k[31:0] ^ t;
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

endpackage

FILE: design/fixed_key_aes_tweak_hash_top.sv
`timescale 1ns / 1ps
// An accepted input word passes through the stage registers st_r[0] to st_r[ROUNDS]; out_valid marks the last one.
// Throughput: one word per cycle while in_stall is low; each of the ten AES rounds has its own pipeline stage.
// Key schedule: a shared round-key unit makes one round key per cycle, so after reset and
// after each key write in_stall is held high while the keys are rebuilt.
// Reset (rst_n low, synchronous) clears the control and key registers and re-expands the all-zero key.
module fixed_key_aes_tweak_hash_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fkaes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fkaes_pkg::HALF_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fkaes_pkg::HALF_W-1:0]      in_block_low,
  input  logic [fkaes_pkg::HALF_W-1:0]      in_block_high,
  input  logic [fkaes_pkg::HALF_W-1:0]      in_tweak,
  input  logic                              in_apply_correction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fkaes_pkg::HALF_W-1:0]      out_hash_low,
  output logic [fkaes_pkg::HALF_W-1:0]      out_hash_high
);
  import fkaes_pkg::*;

  half_t      key_low_r, key_high_r, corr_low_r, corr_high_r;
  block_t     rk_r [ROUNDS+1];
  block_t     cur_key_r;
  round_idx_t rnd_r;
  logic       busy_r;

  block_t     st_r [ROUNDS+1];
  block_t     b_r  [ROUNDS];
  logic       v_r  [ROUNDS+1];
  logic       free [ROUNDS+1];

  block_t     blk_in;
  block_t     new_key;
  logic       key_wr;
  logic       accept;

  // Key registers and the iterative round-key unit.
  always_comb begin
    key_wr  = cfg_wr_en && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);
    new_key = (cfg_index == REG_KEY_LOW) ? {key_high_r, cfg_wdata} : {cfg_wdata, key_low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= '0;
      key_high_r  <= '0;
      corr_low_r  <= '0;
      corr_high_r <= '0;
      rk_r[0]     <= '0;
      cur_key_r   <= '0;
      rnd_r       <= 4'd1;
      busy_r      <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_KEY_LOW:   key_low_r   <= cfg_wdata;
          REG_KEY_HIGH:  key_high_r  <= cfg_wdata;
          REG_CORR_LOW:  corr_low_r  <= cfg_wdata;
          REG_CORR_HIGH: corr_high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (key_wr) begin
        rk_r[0]   <= new_key;
        cur_key_r <= new_key;
        rnd_r     <= 4'd1;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        rk_r[rnd_r] <= next_round_key(cur_key_r, RCON[rnd_r - 4'd1]);
        cur_key_r   <= next_round_key(cur_key_r, RCON[rnd_r - 4'd1]);
        rnd_r       <= rnd_r + 4'd1;
        if (rnd_r == 4'(ROUNDS)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // A stage can load when it is empty or its word moves on in this cycle.
  always_comb begin
    free[ROUNDS] = !v_r[ROUNDS] || !out_stall;
    for (int i = ROUNDS - 1; i >= 0; i--) begin
      free[i] = !v_r[i] || free[i+1];
    end
  end

  assign in_stall = busy_r || !free[0];
  assign accept   = in_valid && !in_stall;
  assign blk_in   = {in_block_high, in_block_low}
                    ^ (in_apply_correction ? {corr_high_r, corr_low_r} : {BLOCK_W{1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ROUNDS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (free[0]) begin
        v_r[0] <= accept;
      end
      for (int i = 1; i <= ROUNDS; i++) begin
        if (free[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      b_r[0]  <= blk_in;
      st_r[0] <= blk_in ^ {{HALF_W{1'b0}}, in_tweak} ^ rk_r[0];
    end
    for (int i = 1; i < ROUNDS; i++) begin
      if (free[i]) begin
        b_r[i]  <= b_r[i-1];
        st_r[i] <= aes_round(st_r[i-1], rk_r[i], 1'b0);
      end
    end
    if (free[ROUNDS]) begin
      st_r[ROUNDS] <= aes_round(st_r[ROUNDS-1], rk_r[ROUNDS], 1'b1) ^ b_r[ROUNDS-1];
    end
  end

  assign out_valid     = v_r[ROUNDS];
  assign out_hash_low  = st_r[ROUNDS][HALF_W-1:0];
  assign out_hash_high = st_r[ROUNDS][BLOCK_W-1:HALF_W];

endmodule

FILE: design/fkaes_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the fixed-key AES tweak hash, bound to the top level.
// Depends on fkaes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fkaes_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fkaes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [fkaes_pkg::HALF_W-1:0]      out_hash_low
);
  import fkaes_pkg::*;

  // Reset starts key expansion, so nothing is taken right after it.
  `CHK_ALWAYS(a_rst_stalls, clk, !rst_n |=> in_stall, "input not stalled after reset")
  `CHK_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "output word present after reset")
  // A key write rebuilds the round keys before new words may enter.
  `CHK_RST(a_key_stalls, clk, rst_n, cfg_wr_en && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH) |=> in_stall, "input open during key expansion")
  `CHK_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_hash_low), "stalled output word changed")

endmodule

bind fixed_key_aes_tweak_hash_top fkaes_checker u_fkaes_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .cfg_wr_en    (cfg_wr_en),
  .cfg_index    (cfg_index),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_hash_low (out_hash_low)
);
